[rtl/remote_frame_sync_assert.svh]
// ----------------------------------------------------------------------------
// remote_frame_sync assertion macros
// Concurrent assertion helpers shared by the frame sync RTL.
// ----------------------------------------------------------------------------
`ifndef REMOTE_FRAME_SYNC_ASSERT_SVH
`define REMOTE_FRAME_SYNC_ASSERT_SVH

// Checked on every clock edge while out of reset.
`define RFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/rfs_pkg.sv]
// ----------------------------------------------------------------------------
// rfs_pkg
// Frame constants and byte classifiers for the remote frame sync block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

  localparam logic [7:0] HdrA = 8'h5B;
  localparam logic [7:0] HdrB = 8'h5C;
  localparam logic [7:0] HdrC = 8'h5D;
  localparam logic [7:0] FtrA = 8'h2B;
  localparam logic [7:0] FtrB = 8'h2C;
  localparam logic [7:0] FtrC = 8'h2D;

  localparam int unsigned FrameLen   = 9;
  localparam int unsigned PayloadLen = 6;
  localparam int unsigned HeadW      = 7;
  localparam int unsigned OutDataW   = 56;  // 7 + 6*8 = 55, padded to bytes

  typedef logic [3:0] pos_t;

  localparam pos_t PosFirstPayload = pos_t'(2);
  localparam pos_t PosFooter       = pos_t'(FrameLen - 1);

  typedef struct packed {
    logic [OutDataW-HeadW-6*8-1:0] pad;
    logic [6*8-1:0]                payload;   // payload_5 .. payload_0
    logic [HeadW-1:0]              head_code;
  } out_data_t;

  function automatic logic is_header(input logic [7:0] b);
    is_header = (b == HdrA) || (b == HdrB) || (b == HdrC);
  endfunction

  function automatic logic footer_ok(input logic [7:0] hdr, input logic [7:0] b);
    footer_ok = ((hdr == HdrA) && (b == FtrA)) ||
                ((hdr == HdrB) && (b == FtrB)) ||
                ((hdr == HdrC) && (b == FtrC));
  endfunction

endpackage

`default_nettype wire

[rtl/remote_frame_sync.sv]
// ----------------------------------------------------------------------------
// remote_frame_sync
// Finds 9-byte remote-control frames in a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  one received byte per item, in arrival order.
//   m_axis_*  one item per good frame: header code plus six payload bytes.
//   A frame is a header byte (0x5B/0x5C/0x5D) sent twice, six payload
//   bytes and a matching footer (0x2B/0x2C/0x2D). A bad footer drops the
//   frame with no output; a different header while waiting for the repeat
//   restarts on that byte, any other byte goes back to hunting.
// Throughput: one byte per cycle while no result is stalled. The sync state update is a single level
//   of compare/select logic feeding the state registers.
// Output: the result item appears on m_axis in the cycle after the footer
//   byte is accepted (output register).
// Reset: clears the sync phase, held header, byte position and the output
//   valid; the payload store is not reset (always written before use).
// Stall: the result waits in the output register. Bytes keep flowing while
//   it is empty or being taken in the same cycle; s_axis_tready drops only
//   while a result is held and m_axis_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module remote_frame_sync
  import rfs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] head_code, [14:7] payload_0, [22:15] payload_1, [30:23] payload_2,
  // [38:31] payload_3, [46:39] payload_4, [54:47] payload_5, [55] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  `include "remote_frame_sync_assert.svh"

  // Sync phase codes
  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhRepeat  = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  pos_t       pos_q, pos_d;
  logic [7:0] payload_q [PayloadLen];

  logic       out_valid_q, out_valid_d;
  out_data_t  out_data_q;

  logic       in_fire;
  logic       frame_ok;
  logic       pay_we;
  logic [2:0] pay_idx;

  // Output register is free when empty or draining this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign pay_idx = 3'(pos_q - PosFirstPayload);

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    pos_d    = pos_q;
    frame_ok = 1'b0;
    pay_we   = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        PhRepeat: begin
          if (s_axis_tdata == hdr_q) begin
            pos_d   = PosFirstPayload;
            phase_d = PhCollect;
          end else if (is_header(s_axis_tdata)) begin
            hdr_d = s_axis_tdata;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCollect: begin
          if (pos_q >= PosFooter) begin
            frame_ok = footer_ok(hdr_q, s_axis_tdata);
            phase_d  = PhHunt;
            pos_d    = '0;
          end else begin
            pay_we = (pos_q >= PosFirstPayload);
            pos_d  = pos_q + pos_t'(1);
          end
        end
        default: begin
          // Hunting; the unused code behaves the same.
          if (is_header(s_axis_tdata)) begin
            hdr_d   = s_axis_tdata;
            phase_d = PhRepeat;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_comb begin
    priority if (frame_ok) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      hdr_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload store: one write port, read in parallel at the footer.
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[pay_idx] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      out_data_q.pad       <= '0;
      out_data_q.head_code <= hdr_q[HeadW-1:0];
      for (int k = 0; k < PayloadLen; k++) begin
        out_data_q.payload[k*8 +: 8] <= payload_q[k];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RFS_ASSERT(a_result_after_footer,
              $rose(out_valid_q) |-> $past(phase_q == PhCollect && pos_q == PosFooter),
              "result raised without a footer byte")
  `RFS_ASSERT(a_collect_pos_range,
              (phase_q == PhCollect) |-> (pos_q >= PosFirstPayload && pos_q <= PosFooter),
              "byte position out of frame range")
  `RFS_ASSERT(a_head_code_valid,
              out_valid_q |-> (out_data_q.head_code == HdrA[HeadW-1:0] ||
                               out_data_q.head_code == HdrB[HeadW-1:0] ||
                               out_data_q.head_code == HdrC[HeadW-1:0]),
              "result carries a non-header code")
  `RFS_ASSERT_ALWAYS(a_no_accept_when_full,
                     (out_valid_q && !m_axis_tready) |-> !s_axis_tready,
                     "byte accepted while result register is stalled")

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams received bytes into remote_frame_sync with random gaps on both
// sides, tracks frame sync in a local predictor and compares every frame
// that comes out against the predicted header code and payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import rfs_pkg::*;

  // Sync phases of the predictor.
  typedef enum logic [1:0] {
    SYNC_HUNT,
    SYNC_REPEAT,
    SYNC_COLLECT
  } sync_e;

  // One decoded frame as it should leave the block.
  typedef struct packed {
    logic [HeadW-1:0]        head;
    logic [PayloadLen-1:0][7:0] pay;
  } frame_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Stimulus and expected frames.
  logic [7:0] byte_fifo [$];
  frame_t     frames_due [$];

  // Predictor state.
  sync_e                 phase = SYNC_HUNT;
  logic [7:0]            held_hdr = 8'h00;
  pos_t                  next_pos = '0;
  logic [PayloadLen-1:0][7:0] pay_bytes = '0;

  // Handshake flags seen at the last rising edge.
  logic byte_taken = 1'b0;
  logic result_taken = 1'b0;

  int src_wait = 0;
  int sink_wait = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  int bytes_queued = 0;
  int bytes_seen = 0;
  int frames_checked = 0;
  int frames_dropped = 0;
  int fail_count = 0;

  remote_frame_sync dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit hdr_byte(input logic [7:0] b);
    return (b == HdrA) || (b == HdrB) || (b == HdrC);
  endfunction

  // Footer that closes a frame opened by the given header.
  function automatic logic [7:0] footer_of(input logic [7:0] hdr);
    case (hdr)
      HdrA:    return FtrA;
      HdrB:    return FtrB;
      HdrC:    return FtrC;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] any_header();
    case ($urandom_range(0, 2))
      0:       return HdrA;
      1:       return HdrB;
      default: return HdrC;
    endcase
  endfunction

  // Random byte, often one of the frame markers to hit the interesting
  // compares.
  function automatic logic [7:0] marker_biased();
    case ($urandom_range(0, 3))
      0:       return any_header();
      1:       return footer_of(any_header());
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int draw_wait(input bit steady);
    if (steady) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_fifo.push_back(b);
    bytes_queued++;
  endtask

  // Header pair, six payload bytes and the given footer.
  task automatic push_frame(input logic [7:0] hdr, input logic [7:0] ftr,
                            input bit markers_in_payload);
    push_byte(hdr);
    push_byte(hdr);
    for (int k = 0; k < PayloadLen; k++)
      push_byte(markers_in_payload ? marker_biased() : 8'($urandom_range(0, 255)));
    push_byte(ftr);
  endtask

  // Predictor: advances the sync state by one accepted byte and queues the
  // frame it completes, if any.
  task track_byte(input logic [7:0] b);
    frame_t f;
    case (phase)
      SYNC_REPEAT: begin
        if (b == held_hdr) begin
          next_pos = PosFirstPayload;
          phase    = SYNC_COLLECT;
        end else if (hdr_byte(b)) begin
          held_hdr = b;  // other header restarts the wait
        end else begin
          phase = SYNC_HUNT;
        end
      end
      SYNC_COLLECT: begin
        if (next_pos >= PosFooter) begin
          if (b == footer_of(held_hdr)) begin
            f.head = held_hdr[HeadW-1:0];
            f.pay  = pay_bytes;
            frames_due.push_back(f);
          end else begin
            frames_dropped++;
          end
          phase    = SYNC_HUNT;
          next_pos = '0;
        end else begin
          // markers inside the frame are plain payload
          if (next_pos >= PosFirstPayload) begin
            pay_bytes[next_pos - PosFirstPayload] = b;
          end
          next_pos = next_pos + pos_t'(1);
        end
      end
      default: begin
        if (hdr_byte(b)) begin
          held_hdr = b;
          phase    = SYNC_REPEAT;
        end else begin
          phase = SYNC_HUNT;
        end
      end
    endcase
  endtask

  // Byte driver: holds an item until taken, then waits its drawn gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (src_wait != 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_fifo.size() != 0) begin
        s_axis_tdata  <= byte_fifo.pop_front();
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 59) == 0) src_steady = !src_steady;
        src_wait = draw_wait(src_steady);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: after each taken result, stalls for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
        sink_wait = draw_wait(sink_steady);
      end
      if (sink_wait != 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks results against the oldest expected frame, then feeds
  // accepted bytes to the predictor.
  always @(posedge clk_i) begin : monitor
    frame_t want;
    logic [7:0] got;
    if (!rst_ni) begin
      byte_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      byte_taken   <= s_axis_tvalid && s_axis_tready;
      result_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got %014h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          frames_checked++;
          if (m_axis_tdata[HeadW-1:0] != want.head) begin
            $display("%0t: head_code expected %02h, got %02h",
                     $time, want.head, m_axis_tdata[HeadW-1:0]);
            fail_count++;
          end
          for (int k = 0; k < PayloadLen; k++) begin
            got = m_axis_tdata[HeadW + 8*k +: 8];
            if (got != want.pay[k]) begin
              $display("%0t: payload_%0d expected %02h, got %02h",
                       $time, k, want.pay[k], got);
              fail_count++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_seen++;
        track_byte(s_axis_tdata);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0] hdr;
    logic [7:0] ftr;
    int         n;

    // Directed: extremes while hunting; a header switch during the wait,
    // markers inside the payload and a good footer; a non-header during the
    // wait; then a frame closed by the wrong footer.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(HdrA);
    push_byte(HdrB);
    push_byte(HdrB);
    push_byte(HdrC);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(HdrA);
    push_byte(FtrA);
    push_byte(8'h80);
    push_byte(FtrB);
    push_byte(HdrC);
    push_byte(8'h07);
    push_byte(HdrC);
    push_byte(HdrC);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_byte(8'h44);
    push_byte(8'h55);
    push_byte(8'h66);
    push_byte(FtrA);

    // Random: mostly well-formed frames, some broken ones and line noise.
    while (bytes_queued < 1545) begin
      hdr = any_header();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          push_frame(hdr, footer_of(hdr), $urandom_range(0, 3) == 0);
        end
        5: begin
          // another random header first (it may match), then the real pair
          push_byte(any_header());
          push_frame(hdr, footer_of(hdr), 1'b0);
        end
        6: begin
          do ftr = marker_biased(); while (ftr == footer_of(hdr));
          push_frame(hdr, ftr, 1'b0);
        end
        7: begin
          // lone header, then a byte that is no header
          push_byte(hdr);
          do ftr = 8'($urandom_range(0, 255)); while (hdr_byte(ftr));
          push_byte(ftr);
        end
        8: begin
          // truncated frame; whatever follows fills it up
          push_byte(hdr);
          push_byte(hdr);
          n = $urandom_range(0, PayloadLen);
          repeat (n) push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          n = $urandom_range(1, 5);
          repeat (n) push_byte(marker_biased());
        end
      endcase
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_fifo.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Streamed %0d bytes; %0d frames came out and were compared, %0d were",
             bytes_seen, frames_checked, frames_dropped);
    $display("dropped on a wrong footer, amid header switches, cut frames and noise.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
